// File: rtl/core/yzv_pkg.sv
// ----------------------------------------------------------------------------
// yzv_pkg: shared constants for the Yang-Zhang rolling volatility block
// Field widths, register indexes, reset values and fixed-point constants.
// ----------------------------------------------------------------------------
package yzv_pkg;

    localparam int MAX_WINDOW_DEF = 256;

    localparam int PRICE_W    = 32;
    localparam int WIN_W      = 9;
    localparam int ANN_W      = 32;
    localparam int BW_W       = 17;
    localparam int VOL_W      = 32;
    localparam int TERM_W     = 48;
    localparam int LOG_W      = 37;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANNUAL_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_WEIGHT   = 2'd2;

    localparam logic [WIN_W-1:0] WIN_RST = 9'd20;
    localparam logic [ANN_W-1:0] ANN_RST = 32'd16515072;
    localparam logic [BW_W-1:0]  BW_RST  = 17'd22282;

    localparam logic [31:0]       LN2_Q32 = 32'hB172_17F8;
    localparam logic [TERM_W-1:0] LN_SAT  = 48'h7FFF_FFFF_FFFF;
    localparam logic [TERM_W-1:0] MAG_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [TERM_W-1:0] RNG_MIN = 48'h8000_0000_0000;
    localparam logic [BW_W-1:0]   K_ONE   = 17'h1_0000;

    // position of the leading one, zero for a zero word
    function automatic logic [4:0] lead_one(input logic [31:0] x);
        logic [4:0] pos;
        pos = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) pos = 5'(i);
        end
        return pos;
    endfunction

endpackage

// File: rtl/core/yang_zhang_rolling_volatility.sv
// ----------------------------------------------------------------------------
// yang_zhang_rolling_volatility: rolling Yang-Zhang volatility estimator
// Per-bar log terms, windowed sums in a ring RAM, annualised square root.
// ----------------------------------------------------------------------------
// Usage
//   Input beat (s_*): one price bar, four unsigned Q16.16 prices.
//   Output beat (m_*): one result per bar: volatility (Q16.16) in tdata,
//   warm and rejected flags in tuser.
//   Config port: plain write, register 0 window length (restarts the
//   window), 1 annual factor, 2 body weight k. Write only while idle.
//   Sequence: a rejected bar goes straight to the output. A valid bar runs
//   five log2 extractions on the shared 33x32 multiplier, six ln
//   scalings, four saturating products and a ring update (read, then
//   write); while the window is filling, the bar ends there. Once warm,
//   three restoring divisions by the bar count, weighting, annualising
//   and a 32-step square root follow.
//   One bar at a time; s_tready is high only while the sequencer idles.
//   The output register frees the input side: a new bar is taken while the
//   previous result waits, and the sequencer holds in its final state only
//   if a result is still pending when the next one is ready.
//   Reset restores the register defaults and clears sums, counters, the
//   previous close and the held volatility; the ring needs no clearing.
// ----------------------------------------------------------------------------
module yang_zhang_rolling_volatility #(
    parameter int MAX_WINDOW = yzv_pkg::MAX_WINDOW_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: open_price, high_price, low_price, close_price (from bit 0)
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [4*yzv_pkg::PRICE_W-1:0]    s_tdata,
    // m_tdata: volatility
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [yzv_pkg::VOL_W-1:0]        m_tdata,
    // m_tuser: warm, rejected (from bit 0)
    output logic [1:0]                       m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [yzv_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [yzv_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    import yzv_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int SUM_W = TERM_W + $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(SUM_W);
    localparam int ACC_W = 51;
    localparam int RAM_W = 3 * TERM_W;

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0_0000_0000_0001,
        S_LOG_INIT = 13'b0_0000_0000_0010,
        S_LOG_ITER = 13'b0_0000_0000_0100,
        S_LN       = 13'b0_0000_0000_1000,
        S_PROD     = 13'b0_0000_0001_0000,
        S_RD       = 13'b0_0000_0010_0000,
        S_UPD      = 13'b0_0000_0100_0000,
        S_DLD      = 13'b0_0000_1000_0000,
        S_DIV      = 13'b0_0001_0000_0000,
        S_VAR      = 13'b0_0010_0000_0000,
        S_ANN      = 13'b0_0100_0000_0000,
        S_SQRT     = 13'b0_1000_0000_0000,
        S_DONE     = 13'b1_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [WIN_W-1:0] wl_reg;
    logic [ANN_W-1:0] af_reg;
    logic [BW_W-1:0]  bw_reg;

    // captured bar
    logic [PRICE_W-1:0] o_reg, h_reg, l_reg, c_reg;
    logic               rej_reg, rej_next;

    // log2 results, e in the top 5 bits
    logic [LOG_W-1:0] lg_o_reg, lg_h_reg, lg_l_reg, lg_c_reg, lg_p_reg;
    logic [LOG_W-1:0] lg_o_next, lg_h_next, lg_l_next, lg_c_next, lg_p_next;
    logic [31:0]      m_reg, m_next, f_reg, f_next;
    logic [4:0]       e_reg, e_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       sel_reg, sel_next;
    logic [1:0]       ph_reg, ph_next;

    // ln ratios, signed Q15.32
    logic signed [TERM_W-1:0] ln_gap_reg, ln_body_reg, ln_hc_reg, ln_ho_reg;
    logic signed [TERM_W-1:0] ln_lc_reg, ln_lo_reg;
    logic signed [TERM_W-1:0] ln_gap_next, ln_body_next, ln_hc_next, ln_ho_next;
    logic signed [TERM_W-1:0] ln_lc_next, ln_lo_next;

    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [TERM_W-1:0]        gsq_reg, gsq_next, bsq_reg, bsq_next;
    logic signed [TERM_W:0]   ra_reg, ra_next;
    logic signed [TERM_W-1:0] rt_reg, rt_next;

    // window state
    logic [SUM_W-1:0]        gap_sum_reg, gap_sum_next, body_sum_reg, body_sum_next;
    logic signed [SUM_W-1:0] rng_sum_reg, rng_sum_next;
    logic [PRICE_W-1:0]      lc_reg, lc_next;
    logic                    hl_reg, hl_next;
    logic [WIN_W-1:0]        fill_reg, fill_next;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [VOL_W-1:0]        vol_reg, vol_next;

    // divider
    logic [WIN_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] dvd_reg, dvd_next;
    logic [TERM_W-1:0] mg_reg, mg_next, mb_reg, mb_next, mr_reg, mr_next;

    // annualise and square root
    logic [63:0] v_reg, v_next, res_reg, res_next, bit_reg, bit_next;

    // output register
    logic             mv_reg, mv_next;
    logic [VOL_W-1:0] mdata_reg, mdata_next;
    logic             mwarm_reg, mwarm_next, mrej_reg, mrej_next;

    // shared multiplier
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] mul_p;
    assign mul_p = 65'(mul_a) * 65'(mul_b);

    // ring RAM: {body, range, gap}
    logic              ram_we;
    logic [AW-1:0]     ram_raddr;
    logic [RAM_W-1:0]  ram_wdata, ram_rdata;

    yzv_ram #(
        .DATA_W (RAM_W),
        .DEPTH  (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (wp_reg),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // input fields
    logic [PRICE_W-1:0] in_open, in_high, in_low, in_close;
    logic               bar_bad;
    assign in_open  = s_tdata[PRICE_W-1:0];
    assign in_high  = s_tdata[2*PRICE_W-1:PRICE_W];
    assign in_low   = s_tdata[3*PRICE_W-1:2*PRICE_W];
    assign in_close = s_tdata[4*PRICE_W-1:3*PRICE_W];
    assign bar_bad  = (in_open == '0) || (in_low == '0) || (in_high < in_low);

    assign s_tready = (state_reg == S_IDLE);

    // effective window and weights
    logic [WIN_W-1:0] p_eff;
    logic             warm_now;
    logic [BW_W-1:0]  k_eff, k_cmp;

    always_comb begin
        if (wl_reg == '0) p_eff = WIN_W'(1);
        else if (32'(wl_reg) > 32'(MAX_WINDOW)) p_eff = WIN_W'(MAX_WINDOW);
        else p_eff = wl_reg;
    end
    assign warm_now = (fill_reg >= p_eff);
    assign k_eff    = (bw_reg > K_ONE) ? K_ONE : bw_reg;
    assign k_cmp    = K_ONE - k_eff;

    // operand selection helpers
    logic [PRICE_W-1:0]        log_x, ln_ra, ln_rb;
    logic [LOG_W-1:0]          ln_la, ln_lb, ln_d;
    logic                      ln_neg;
    logic [32:0]               sq;
    logic signed [TERM_W-1:0]  op_a, op_b, ln_val;
    logic [TERM_W-1:0]         ma, mb, mag, r48;
    logic [ACC_W-1:0]          tot;
    logic signed [TERM_W:0]    sval;
    logic signed [TERM_W+1:0]  rs_sum;
    logic                      ge;
    logic [WIN_W:0]            sh;
    logic [SUM_W-1:0]          q;
    logic [64:0]               s65;
    logic [63:0]               trial;
    logic [AW-1:0]             wp_use;
    logic [TERM_W-1:0]         old_gap, old_body;
    logic signed [TERM_W-1:0]  old_rng;
    logic [WIN_W-1:0]          fill_new;

    assign old_gap  = ram_rdata[TERM_W-1:0];
    assign old_rng  = ram_rdata[2*TERM_W-1:TERM_W];
    assign old_body = ram_rdata[3*TERM_W-1:2*TERM_W];
    assign wp_use   = (32'(wp_reg) >= 32'(p_eff)) ? '0 : wp_reg;
    assign ram_raddr = wp_use;

    always_comb begin
        case (sel_reg)
            3'd0:    log_x = o_reg;
            3'd1:    log_x = h_reg;
            3'd2:    log_x = l_reg;
            3'd3:    log_x = c_reg;
            default: log_x = lc_reg;
        endcase
    end

    always_comb begin
        case (sel_reg)
            3'd0: begin ln_la = lg_o_reg; ln_lb = lg_p_reg; ln_ra = o_reg; ln_rb = lc_reg; end
            3'd1: begin ln_la = lg_c_reg; ln_lb = lg_o_reg; ln_ra = c_reg; ln_rb = o_reg;  end
            3'd2: begin ln_la = lg_h_reg; ln_lb = lg_c_reg; ln_ra = h_reg; ln_rb = c_reg;  end
            3'd3: begin ln_la = lg_h_reg; ln_lb = lg_o_reg; ln_ra = h_reg; ln_rb = o_reg;  end
            3'd4: begin ln_la = lg_l_reg; ln_lb = lg_c_reg; ln_ra = l_reg; ln_rb = c_reg;  end
            default: begin
                ln_la = lg_l_reg; ln_lb = lg_o_reg; ln_ra = l_reg; ln_rb = o_reg;
            end
        endcase
        ln_neg = (ln_la < ln_lb);
        ln_d   = ln_neg ? (ln_lb - ln_la) : (ln_la - ln_lb);
    end

    always_comb begin
        case (sel_reg)
            3'd0:    begin op_a = ln_gap_reg;  op_b = ln_gap_reg;  end
            3'd1:    begin op_a = ln_body_reg; op_b = ln_body_reg; end
            3'd2:    begin op_a = ln_hc_reg;   op_b = ln_ho_reg;   end
            default: begin op_a = ln_lc_reg;   op_b = ln_lo_reg;   end
        endcase
        ma = op_a[TERM_W-1] ? TERM_W'(-op_a) : op_a;
        mb = op_b[TERM_W-1] ? TERM_W'(-op_b) : op_b;
    end

    // multiplier operand mux
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_LOG_ITER: begin
                mul_a = {1'b0, m_reg};
                mul_b = m_reg;
            end
            S_LN: begin
                mul_b = LN2_Q32;
                mul_a = (ph_reg == 2'd0) ? {1'b0, ln_d[31:0]} : 33'(ln_d[LOG_W-1:32]);
            end
            S_PROD: begin
                case (ph_reg)
                    2'd0: begin mul_a = {1'b0, ma[31:0]};        mul_b = mb[31:0]; end
                    2'd1: begin mul_a = 33'(ma[TERM_W-1:32]);    mul_b = mb[31:0]; end
                    2'd2: begin mul_a = {1'b0, ma[31:0]};        mul_b = 32'(mb[TERM_W-1:32]); end
                    default: begin
                        mul_a = 33'(ma[TERM_W-1:32]);
                        mul_b = 32'(mb[TERM_W-1:32]);
                    end
                endcase
            end
            S_VAR: begin
                case (ph_reg)
                    2'd0: begin mul_a = 33'(k_eff); mul_b = mb_reg[TERM_W-1:16]; end
                    2'd1: begin mul_a = 33'(k_eff); mul_b = 32'(mb_reg[15:0]);   end
                    2'd2: begin mul_a = 33'(k_cmp); mul_b = mr_reg[TERM_W-1:16]; end
                    default: begin mul_a = 33'(k_cmp); mul_b = 32'(mr_reg[15:0]); end
                endcase
            end
            S_ANN: begin
                mul_b = af_reg;
                mul_a = (ph_reg == 2'd0) ? 33'(acc_reg[ACC_W-1:32]) : {1'b0, acc_reg[31:0]};
            end
            default: ;
        endcase
    end

    // derived values of the shared unit
    always_comb begin
        sq  = mul_p[63:31];
        r48 = mul_p[TERM_W-1:0] + acc_reg[TERM_W-1:0];
        if (ln_ra == '0 && ln_rb == '0) ln_val = '0;
        else if (ln_ra == '0)           ln_val = -$signed(LN_SAT);
        else if (ln_rb == '0)           ln_val = LN_SAT;
        else if (ln_neg)                ln_val = -$signed(r48);
        else                            ln_val = r48;

        tot = acc_reg + {3'b0, mul_p[15:0], 32'b0};
        mag = ((mul_p[31:16] != '0) || (tot > ACC_W'(MAG_MAX))) ? MAG_MAX : tot[TERM_W-1:0];
        sval = (op_a[TERM_W-1] ^ op_b[TERM_W-1]) ? -$signed({1'b0, mag})
                                                 : $signed({1'b0, mag});
        rs_sum = (TERM_W+2)'(ra_reg) + (TERM_W+2)'(sval);

        sh = {rem_reg, dvd_reg[SUM_W-1]};
        ge = (sh >= {1'b0, fill_reg});
        q  = {dvd_reg[SUM_W-2:0], ge};

        s65   = {1'b0, v_reg[TERM_W-1:0], 16'b0} + 65'(mul_p[63:16]);
        trial = res_reg + bit_reg;
        fill_new = warm_now ? fill_reg : fill_reg + WIN_W'(1);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        rej_next = rej_reg;
        lg_o_next = lg_o_reg; lg_h_next = lg_h_reg; lg_l_next = lg_l_reg;
        lg_c_next = lg_c_reg; lg_p_next = lg_p_reg;
        m_next = m_reg; f_next = f_reg; e_next = e_reg;
        cnt_next = cnt_reg; sel_next = sel_reg; ph_next = ph_reg;
        ln_gap_next = ln_gap_reg; ln_body_next = ln_body_reg;
        ln_hc_next = ln_hc_reg; ln_ho_next = ln_ho_reg;
        ln_lc_next = ln_lc_reg; ln_lo_next = ln_lo_reg;
        acc_next = acc_reg;
        gsq_next = gsq_reg; bsq_next = bsq_reg; ra_next = ra_reg; rt_next = rt_reg;
        gap_sum_next = gap_sum_reg; body_sum_next = body_sum_reg;
        rng_sum_next = rng_sum_reg;
        lc_next = lc_reg; hl_next = hl_reg; fill_next = fill_reg; wp_next = wp_reg;
        vol_next = vol_reg;
        rem_next = rem_reg; dvd_next = dvd_reg;
        mg_next = mg_reg; mb_next = mb_reg; mr_next = mr_reg;
        v_next = v_reg; res_next = res_reg; bit_next = bit_reg;
        mdata_next = mdata_reg; mwarm_next = mwarm_reg; mrej_next = mrej_reg;
        mv_next = mv_reg && !m_tready;
        ram_we = 1'b0;
        ram_wdata = {bsq_reg, rt_reg, gsq_reg};

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    rej_next = bar_bad;
                    sel_next = '0;
                    state_next = bar_bad ? S_DONE : S_LOG_INIT;
                end
            end
            S_LOG_INIT: begin
                e_next = lead_one(log_x);
                m_next = log_x << (5'd31 - lead_one(log_x));
                f_next = '0;
                cnt_next = '0;
                state_next = S_LOG_ITER;
            end
            S_LOG_ITER: begin
                // square, renormalise, shift one fraction bit in
                f_next = {f_reg[30:0], sq[32]};
                m_next = sq[32] ? sq[32:1] : sq[31:0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(31)) begin
                    case (sel_reg)
                        3'd0:    lg_o_next = {e_reg, f_next};
                        3'd1:    lg_h_next = {e_reg, f_next};
                        3'd2:    lg_l_next = {e_reg, f_next};
                        3'd3:    lg_c_next = {e_reg, f_next};
                        default: lg_p_next = {e_reg, f_next};
                    endcase
                    if (sel_reg == 3'd4) begin
                        sel_next = '0;
                        ph_next = '0;
                        state_next = S_LN;
                    end else begin
                        sel_next = sel_reg + 3'd1;
                        state_next = S_LOG_INIT;
                    end
                end
            end
            S_LN: begin
                if (ph_reg == 2'd0) begin
                    acc_next = ACC_W'(mul_p[63:32]);
                    ph_next = 2'd1;
                end else begin
                    case (sel_reg)
                        3'd0:    ln_gap_next  = ln_val;
                        3'd1:    ln_body_next = ln_val;
                        3'd2:    ln_hc_next   = ln_val;
                        3'd3:    ln_ho_next   = ln_val;
                        3'd4:    ln_lc_next   = ln_val;
                        default: ln_lo_next   = ln_val;
                    endcase
                    ph_next = 2'd0;
                    if (sel_reg == 3'd5) begin
                        sel_next = '0;
                        state_next = S_PROD;
                    end else begin
                        sel_next = sel_reg + 3'd1;
                    end
                end
            end
            S_PROD: begin
                ph_next = ph_reg + 2'd1;
                case (ph_reg)
                    2'd0:    acc_next = ACC_W'(mul_p[63:32]);
                    2'd1,
                    2'd2:    acc_next = acc_reg + ACC_W'(mul_p[TERM_W-1:0]);
                    default: begin
                        case (sel_reg)
                            3'd0: gsq_next = (hl_reg && lc_reg != '0) ? mag : '0;
                            3'd1: bsq_next = mag;
                            3'd2: ra_next = sval;
                            default: begin
                                if (rs_sum[TERM_W+1:TERM_W-1] == 3'b000 ||
                                    rs_sum[TERM_W+1:TERM_W-1] == 3'b111)
                                    rt_next = rs_sum[TERM_W-1:0];
                                else if (rs_sum[TERM_W+1])
                                    rt_next = RNG_MIN;
                                else
                                    rt_next = LN_SAT;
                            end
                        endcase
                        if (sel_reg == 3'd3) state_next = S_RD;
                        else sel_next = sel_reg + 3'd1;
                    end
                endcase
            end
            S_RD: begin
                wp_next = wp_use;
                state_next = S_UPD;
            end
            S_UPD: begin
                ram_we = 1'b1;
                gap_sum_next = gap_sum_reg - SUM_W'(warm_now ? old_gap : '0)
                             + SUM_W'(gsq_reg);
                body_sum_next = body_sum_reg - SUM_W'(warm_now ? old_body : '0)
                              + SUM_W'(bsq_reg);
                // range terms are signed: sign-extend before the subtract
                rng_sum_next = rng_sum_reg - (warm_now ? SUM_W'(old_rng) : SUM_W'(0))
                             + SUM_W'(rt_reg);
                fill_next = fill_new;
                wp_next = (32'(wp_reg) + 32'd1 >= 32'(p_eff)) ? '0 : wp_reg + AW'(1);
                lc_next = c_reg;
                hl_next = 1'b1;
                sel_next = '0;
                state_next = (fill_new >= p_eff) ? S_DLD : S_DONE;
            end
            S_DLD: begin
                case (sel_reg)
                    3'd0:    dvd_next = gap_sum_reg;
                    3'd1:    dvd_next = body_sum_reg;
                    default: dvd_next = (!rng_sum_reg[SUM_W-1] && rng_sum_reg != '0)
                                        ? SUM_W'(rng_sum_reg) : '0;
                endcase
                rem_next = '0;
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                // restoring division by the bar count, one bit a cycle
                rem_next = ge ? WIN_W'(sh - {1'b0, fill_reg}) : sh[WIN_W-1:0];
                dvd_next = q;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                    case (sel_reg)
                        3'd0:    mg_next = q[TERM_W-1:0];
                        3'd1:    mb_next = q[TERM_W-1:0];
                        default: mr_next = q[TERM_W-1:0];
                    endcase
                    if (sel_reg == 3'd2) begin
                        ph_next = '0;
                        state_next = S_VAR;
                    end else begin
                        sel_next = sel_reg + 3'd1;
                        state_next = S_DLD;
                    end
                end
            end
            S_VAR: begin
                ph_next = ph_reg + 2'd1;
                case (ph_reg)
                    2'd0:    acc_next = ACC_W'(mg_reg) + ACC_W'(mul_p[48:0]);
                    2'd1:    acc_next = acc_reg + ACC_W'(mul_p[32:16]);
                    2'd2:    acc_next = acc_reg + ACC_W'(mul_p[48:0]);
                    default: begin
                        acc_next = acc_reg + ACC_W'(mul_p[32:16]);
                        state_next = S_ANN;
                    end
                endcase
            end
            S_ANN: begin
                res_next = '0;
                bit_next = 64'h4000_0000_0000_0000;
                cnt_next = '0;
                if (ph_reg == 2'd0) begin
                    if (mul_p[64:TERM_W] != '0) begin
                        v_next = '1;
                        state_next = S_SQRT;
                    end else begin
                        v_next = 64'(mul_p[TERM_W-1:0]);
                        ph_next = 2'd1;
                    end
                end else begin
                    v_next = s65[64] ? '1 : s65[63:0];
                    ph_next = 2'd0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (v_reg >= trial) begin
                    v_next = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(31)) begin
                    vol_next = res_next[VOL_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next = 1'b1;
                    mdata_next = vol_reg;
                    mwarm_next = warm_now;
                    mrej_next = rej_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // window length write restarts the window
        if (cfg_wr_en && cfg_index == REG_WINDOW_LENGTH) begin
            gap_sum_next = '0;
            body_sum_next = '0;
            rng_sum_next = '0;
            fill_next = '0;
            wp_next = '0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mv_reg <= 1'b0;
            wl_reg <= WIN_RST;
            af_reg <= ANN_RST;
            bw_reg <= BW_RST;
            gap_sum_reg <= '0;
            body_sum_reg <= '0;
            rng_sum_reg <= '0;
            lc_reg <= '0;
            hl_reg <= 1'b0;
            fill_reg <= '0;
            wp_reg <= '0;
            vol_reg <= '0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
            gap_sum_reg <= gap_sum_next;
            body_sum_reg <= body_sum_next;
            rng_sum_reg <= rng_sum_next;
            lc_reg <= lc_next;
            hl_reg <= hl_next;
            fill_reg <= fill_next;
            wp_reg <= wp_next;
            vol_reg <= vol_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_WINDOW_LENGTH: wl_reg <= cfg_wr_data[WIN_W-1:0];
                    REG_ANNUAL_FACTOR: af_reg <= cfg_wr_data[ANN_W-1:0];
                    REG_BODY_WEIGHT:   bw_reg <= cfg_wr_data[BW_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            o_reg <= in_open;
            h_reg <= in_high;
            l_reg <= in_low;
            c_reg <= in_close;
        end
        rej_reg <= rej_next;
        lg_o_reg <= lg_o_next; lg_h_reg <= lg_h_next; lg_l_reg <= lg_l_next;
        lg_c_reg <= lg_c_next; lg_p_reg <= lg_p_next;
        m_reg <= m_next; f_reg <= f_next; e_reg <= e_next;
        cnt_reg <= cnt_next; sel_reg <= sel_next; ph_reg <= ph_next;
        ln_gap_reg <= ln_gap_next; ln_body_reg <= ln_body_next;
        ln_hc_reg <= ln_hc_next; ln_ho_reg <= ln_ho_next;
        ln_lc_reg <= ln_lc_next; ln_lo_reg <= ln_lo_next;
        acc_reg <= acc_next;
        gsq_reg <= gsq_next; bsq_reg <= bsq_next; ra_reg <= ra_next; rt_reg <= rt_next;
        rem_reg <= rem_next; dvd_reg <= dvd_next;
        mg_reg <= mg_next; mb_reg <= mb_next; mr_reg <= mr_next;
        v_reg <= v_next; res_reg <= res_next; bit_reg <= bit_next;
        mdata_reg <= mdata_next; mwarm_reg <= mwarm_next; mrej_reg <= mrej_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = {mrej_reg, mwarm_reg};

endmodule

// File: rtl/core/yzv_ram.sv
// ----------------------------------------------------------------------------
// yzv_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module yzv_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/yzv_checker.sv
// ----------------------------------------------------------------------------
// yzv_checker: port-level checks for the rolling volatility block
// Bound to the top level; watches the stream ports only.
// ----------------------------------------------------------------------------
module yzv_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [yzv_pkg::VOL_W-1:0] m_tdata,
    input logic [1:0]                m_tuser
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat valid after reset");

    // one bar at a time: busy right after taking a beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a bar is in flight");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind yang_zhang_rolling_volatility yzv_checker u_yzv_checker (.*);
